// ===== src/i2c_seq_pkg.sv =====
`default_nettype none

package i2c_seq_pkg;

    // command codes carried on the input channel
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_READ    = 3'd4,
        CMD_RECOVER = 3'd5
    } cmd_t;

    // sequencer state, one-hot
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_START   = 6'b000010,
        ST_STOP    = 6'b000100,
        ST_WRITE   = 6'b001000,
        ST_READ    = 6'b010000,
        ST_RECOVER = 6'b100000
    } state_t;

    localparam int PHASE_W = 5;
    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;

    localparam logic [TICK_W-1:0] RESET_PHASE_LENGTH = 16'd160;

    // phase numbering
    localparam int RECOVER_PULSES = 9;
    localparam logic [PHASE_W-1:0] BIT_PHASES       = PHASE_W'(2 * BYTE_W);
    localparam logic [PHASE_W-1:0] LAST_BIT_PHASE   = PHASE_W'(2 * BYTE_W - 1);
    localparam logic [PHASE_W-1:0] RECOVER_LAST_PAIR = PHASE_W'(2 * RECOVER_PULSES - 1);
    localparam logic [PHASE_W-1:0] RECOVER_SCL_UP   = PHASE_W'(2 * RECOVER_PULSES);
    localparam logic [PHASE_W-1:0] RECOVER_SDA_UP   = PHASE_W'(2 * RECOVER_PULSES + 1);

    // number of delay phases each command walks through
    function automatic logic [PHASE_W-1:0] phase_total(input state_t st);
        logic [PHASE_W-1:0] n;
        case (st)
            ST_START:   n = 5'd2;
            ST_STOP:    n = 5'd3;
            ST_WRITE:   n = PHASE_W'(2 * BYTE_W + 2);
            ST_READ:    n = PHASE_W'(2 * BYTE_W + 2);
            ST_RECOVER: n = PHASE_W'(2 * RECOVER_PULSES + 3);
            default:    n = 5'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/i2c_master_byte_sequencer.sv =====
// I2C master byte sequencer.
// Every transfer on the s_ channel is one bus tick: it carries the sampled SDA
// level and, in s_tuser, an optional command (start, stop, write byte, read
// byte, bus recovery). A command is taken only while the sequencer is idle;
// commands that arrive while busy are dropped. The sequencer then walks a
// fixed list of delay phases, each cfg phase_length ticks long, and changes
// the open-drain SCL/SDA drive levels at phase ends, sampling SDA there too.
// Every input transfer yields exactly one m_ transfer with the pin drives,
// busy, a one-tick done pulse, the ACK flag of the last write and the byte of
// the last read. Each result is registered in the output register; one
// transfer per cycle is accepted as long as the output side keeps up.
// When m_tready is low with a result held, s_tready drops until that result
// is taken; the state advances only on accepted transfers.
// Reset (aresetn low, synchronous) releases both lines, goes idle, clears the
// ACK flag and read byte and sets phase_length to 160 ticks.
// cfg_wr_en writes phase_length at any clock edge; it should be written idle.
`default_nettype none

module i2c_master_byte_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // data_byte[7:0], send_ack[8], sda_in[9]
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // scl_out[0], sda_out[1], busy_res[2],
                                        // done_res[3], ack_received[4],
                                        // read_data[12:5]
);
    import i2c_seq_pkg::*;

    logic [TICK_W-1:0]  phase_length_reg;
    state_t             state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic               ack_choice_reg, ack_choice_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               ack_flag_reg, ack_flag_next;
    logic [BYTE_W-1:0]  rdata_reg, rdata_next;
    logic               done_next;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    cmd_t               cmd;
    logic [BYTE_W-1:0]  data_byte;
    logic               send_ack;
    logic               sda_in;
    logic               accept;
    logic               phase_end;
    logic               last_phase;
    logic [BYTE_W-1:0]  shifted;

    assign cmd       = cmd_t'(s_tuser);
    assign data_byte = s_tdata[7:0];
    assign send_ack  = s_tdata[8];
    assign sda_in    = s_tdata[9];

    // output register: take a new transfer when empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // phase timer and end-of-command detection
    assign phase_end  = ({1'b0, tick_reg} + 17'd1) >= {1'b0, phase_length_reg};
    assign last_phase = ({1'b0, phase_reg} + 6'd1) >= {1'b0, phase_total(state_reg)};
    assign shifted    = {shift_reg[BYTE_W-2:0], 1'b0};

    // next state for one tick
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_flag_next   = ack_flag_reg;
        rdata_next      = rdata_reg;
        done_next       = 1'b0;

        if (state_reg == ST_IDLE) begin
            // command launch
            case (cmd)
                CMD_START: begin
                    state_next = ST_START;
                    phase_next = '0;
                    tick_next  = '0;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                CMD_RECOVER: begin
                    state_next = ST_RECOVER;
                    phase_next = '0;
                    tick_next  = '0;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                CMD_STOP: begin
                    state_next = ST_STOP;
                    phase_next = '0;
                    tick_next  = '0;
                    sda_next   = 1'b0;
                end
                CMD_WRITE: begin
                    state_next = ST_WRITE;
                    phase_next = '0;
                    tick_next  = '0;
                    shift_next = data_byte;
                    sda_next   = data_byte[BYTE_W-1];
                end
                CMD_READ: begin
                    state_next      = ST_READ;
                    phase_next      = '0;
                    tick_next       = '0;
                    shift_next      = '0;
                    ack_choice_next = send_ack;
                    sda_next        = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (phase_end) begin
            tick_next = '0;
            // pin changes at the end of each phase
            case (state_reg)
                ST_START: begin
                    if (phase_reg == '0) begin
                        sda_next = 1'b0;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                ST_STOP: begin
                    if (phase_reg == 5'd0) begin
                        scl_next = 1'b1;
                    end else if (phase_reg == 5'd1) begin
                        sda_next = 1'b1;
                    end
                end
                ST_WRITE: begin
                    if (phase_reg < BIT_PHASES) begin
                        if (!phase_reg[0]) begin
                            scl_next = 1'b1;
                        end else begin
                            scl_next   = 1'b0;
                            shift_next = shifted;
                            sda_next   = (phase_reg == LAST_BIT_PHASE) ? 1'b1
                                                                       : shifted[BYTE_W-1];
                        end
                    end else if (phase_reg == BIT_PHASES) begin
                        scl_next = 1'b1;
                    end else begin
                        ack_flag_next = !sda_in;
                        scl_next      = 1'b0;
                    end
                end
                ST_READ: begin
                    if (phase_reg < BIT_PHASES) begin
                        if (!phase_reg[0]) begin
                            scl_next = 1'b1;
                        end else begin
                            shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                            scl_next   = 1'b0;
                            if (phase_reg == LAST_BIT_PHASE) begin
                                sda_next = !ack_choice_reg;
                            end
                        end
                    end else if (phase_reg == BIT_PHASES) begin
                        scl_next = 1'b1;
                    end else begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        rdata_next = shift_reg;
                    end
                end
                ST_RECOVER: begin
                    if (phase_reg <= RECOVER_LAST_PAIR) begin
                        if (!phase_reg[0]) begin
                            scl_next = 1'b0;
                        end else if (phase_reg < RECOVER_LAST_PAIR) begin
                            scl_next = 1'b1;
                        end else begin
                            sda_next = 1'b0;
                        end
                    end else if (phase_reg == RECOVER_SCL_UP) begin
                        scl_next = 1'b1;
                    end else if (phase_reg == RECOVER_SDA_UP) begin
                        sda_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // advance, or finish the command
            if (last_phase) begin
                state_next = ST_IDLE;
                phase_next = '0;
                done_next  = 1'b1;
            end else begin
                phase_next = phase_reg + 5'd1;
            end
        end else begin
            tick_next = tick_reg + 16'd1;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_length_reg <= RESET_PHASE_LENGTH;
        end else if (cfg_wr_en) begin
            phase_length_reg <= cfg_wr_data;
        end
    end

    // sequencer state, advanced once per accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= '0;
            tick_reg       <= '0;
            shift_reg      <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_flag_reg   <= 1'b0;
            rdata_reg      <= '0;
        end else if (accept) begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_flag_reg   <= ack_flag_next;
            rdata_reg      <= rdata_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000, rdata_next, ack_flag_next, done_next,
                            (state_next != ST_IDLE), sda_next, scl_next};
        end
    end

endmodule

`default_nettype wire

// ===== bench/i2c_master_byte_sequencer_test.sv =====
`default_nettype none

module i2c_master_byte_sequencer_test;
    import i2c_seq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int START_PHASES   = 2;
    localparam int STOP_PHASES    = 3;
    localparam int BYTE_PHASES    = 18;
    localparam int RECOVER_PHASES = 21;
    localparam int STALL_LIMIT    = 3000;
    localparam int PHASE_TICKS    = 30;

    // one result transfer, same layout as m_tdata[12:0]
    typedef struct packed {
        logic [7:0] rd_byte;
        logic       ack;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } bus_view_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = 16'd0;   // data_byte[7:0], send_ack[8], sda_in[9]
    logic [2:0]  s_tuser     = 3'd0;    // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;               // scl_out[0], sda_out[1], busy_res[2],
                                        // done_res[3], ack_received[4], read_data[12:5]

    i2c_master_byte_sequencer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // sequencer mirror
    int         phase_len   = 160;
    cmd_t       seq_cmd     = CMD_NONE;
    int         seq_phase   = 0;
    int         seq_ticks   = 0;
    logic [7:0] seq_shift   = 8'd0;
    logic       seq_ack_sel = 1'b0;
    logic       pin_scl     = 1'b1;
    logic       pin_sda     = 1'b1;
    logic       last_ack    = 1'b0;
    logic [7:0] last_read   = 8'd0;

    bus_view_t  pin_forecast[$];
    int         error_count = 0;
    int         gap_pct     = 0;
    int         stall_pct   = 0;
    int         noise_pct   = 10;
    int         ticks_sent  = 0;
    int         quiet_cycles = 0;
    bus_view_t  mon_want;
    bus_view_t  mon_got;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // advance the mirror by one bus tick and return the pins it shows afterwards
    function automatic bus_view_t step_sequencer(cmd_t c, logic [7:0] d, logic ack_in,
                                                 logic sda_bit);
        bus_view_t v;
        logic      finished;
        int        p;
        int        total;
        finished = 1'b0;
        p = seq_phase;
        if (seq_cmd == CMD_NONE) begin
            // idle: only the five real commands are taken
            if (c >= CMD_START && c <= CMD_RECOVER) begin
                seq_cmd = c;
                seq_phase = 0;
                seq_ticks = 0;
                case (c)
                    CMD_START, CMD_RECOVER: begin
                        pin_sda = 1'b1;
                        pin_scl = 1'b1;
                    end
                    CMD_STOP: pin_sda = 1'b0;
                    CMD_WRITE: begin
                        seq_shift = d;
                        pin_sda = d[7];
                    end
                    default: begin
                        seq_shift = 8'd0;
                        seq_ack_sel = ack_in;
                        pin_sda = 1'b1;
                    end
                endcase
            end
        end else if (seq_ticks + 1 >= phase_len) begin
            // end of a delay phase: pin changes and sampling
            seq_ticks = 0;
            case (seq_cmd)
                CMD_START: begin
                    if (p == 0) pin_sda = 1'b0;
                    else pin_scl = 1'b0;
                    total = START_PHASES;
                end
                CMD_STOP: begin
                    if (p == 0) pin_scl = 1'b1;
                    else if (p == 1) pin_sda = 1'b1;
                    total = STOP_PHASES;
                end
                CMD_WRITE: begin
                    if (p < 16) begin
                        if (p % 2 == 0) begin
                            pin_scl = 1'b1;
                        end else begin
                            pin_scl = 1'b0;
                            seq_shift = seq_shift << 1;
                            pin_sda = (p == 15) ? 1'b1 : seq_shift[7];
                        end
                    end else if (p == 16) begin
                        pin_scl = 1'b1;
                    end else begin
                        last_ack = ~sda_bit;
                        pin_scl = 1'b0;
                    end
                    total = BYTE_PHASES;
                end
                CMD_READ: begin
                    if (p < 16) begin
                        if (p % 2 == 0) begin
                            pin_scl = 1'b1;
                        end else begin
                            seq_shift = {seq_shift[6:0], sda_bit};
                            pin_scl = 1'b0;
                            if (p == 15) pin_sda = ~seq_ack_sel;
                        end
                    end else if (p == 16) begin
                        pin_scl = 1'b1;
                    end else begin
                        pin_scl = 1'b0;
                        pin_sda = 1'b1;
                        last_read = seq_shift;
                    end
                    total = BYTE_PHASES;
                end
                default: begin
                    // recovery: clock pulses on scl, the last pair pulls sda low instead of raising scl
                    if (p <= 17) begin
                        if (p % 2 == 0) pin_scl = 1'b0;
                        else if (p < 17) pin_scl = 1'b1;
                        else pin_sda = 1'b0;
                    end else if (p == 18) begin
                        pin_scl = 1'b1;
                    end else if (p == 19) begin
                        pin_sda = 1'b1;
                    end
                    total = RECOVER_PHASES;
                end
            endcase
            seq_phase = seq_phase + 1;
            if (seq_phase >= total) begin
                seq_cmd = CMD_NONE;
                seq_phase = 0;
                finished = 1'b1;
            end
        end else begin
            seq_ticks = seq_ticks + 1;
        end
        v.scl = pin_scl;
        v.sda = pin_sda;
        v.busy = (seq_cmd != CMD_NONE);
        v.done = finished;
        v.ack = last_ack;
        v.rd_byte = last_read;
        return v;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        error_count = error_count + 1;
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want_v, got_v);
    endtask

    function automatic logic pick_sda(int sel);
        return (sel < 0) ? logic'($urandom_range(1)) : sel[0];
    endfunction

    // one input transfer, with random gaps before it
    task automatic send_tick(cmd_t c, logic [7:0] d, logic ack_bit, logic sda_bit);
        bit took;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {6'd0, sda_bit, ack_bit, d};
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        ticks_sent = ticks_sent + 1;
        pin_forecast.push_back(step_sequencer(c, d, ack_bit, sda_bit));
    endtask

    // issue a command, then tick until it completes, with ignored commands mixed in
    task automatic run_command(cmd_t c, logic [7:0] d, logic ack_bit, int sda_sel);
        cmd_t extra;
        send_tick(c, d, ack_bit, pick_sda(sda_sel));
        while (seq_cmd != CMD_NONE) begin
            extra = ($urandom_range(99) < noise_pct) ? cmd_t'($urandom_range(7)) : CMD_NONE;
            send_tick(extra, 8'($urandom), logic'($urandom_range(1)), pick_sda(sda_sel));
        end
    endtask

    // register write once every result is back
    task automatic write_phase_length(logic [15:0] v);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pin_forecast.size() != 0);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        phase_len = int'(v);
    endtask

    task automatic test_reset_state();
        repeat (3) send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
        run_command(CMD_START, 8'h00, 1'b0, -1);
    endtask

    task automatic test_each_command();
        write_phase_length(16'd1);
        run_command(CMD_START, 8'h00, 1'b0, -1);
        run_command(CMD_WRITE, 8'h00, 1'b1, 0);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 1);
        run_command(CMD_WRITE, 8'hA5, 1'b0, -1);
        run_command(CMD_START, 8'h00, 1'b0, -1);
        run_command(CMD_READ, 8'hFF, 1'b1, 0);
        run_command(CMD_READ, 8'h00, 1'b0, 1);
        run_command(CMD_READ, 8'h5A, 1'b1, -1);
        // unused codes while idle are dropped
        send_tick(cmd_t'(3'd6), 8'hFF, 1'b1, 1'b0);
        send_tick(cmd_t'(3'd7), 8'h00, 1'b0, 1'b1);
        // commands arriving while busy are dropped
        noise_pct = 60;
        run_command(CMD_WRITE, 8'h3C, 1'b1, -1);
        noise_pct = 10;
        run_command(CMD_STOP, 8'h00, 1'b0, -1);
        run_command(CMD_RECOVER, 8'h00, 1'b0, -1);
        write_phase_length(16'd2);
        run_command(CMD_READ, 8'h00, 1'b0, -1);
        // zero length phases act as one tick each
        write_phase_length(16'd0);
        run_command(CMD_WRITE, 8'h81, 1'b0, -1);
        run_command(CMD_RECOVER, 8'h00, 1'b1, -1);
    endtask

    task automatic test_phase_length_extremes();
        write_phase_length(16'hFFFF);
        send_tick(CMD_START, 8'h00, 1'b0, 1'b1);
        repeat (30) send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
        // a shorter length written mid-phase ends the running phase at once
        write_phase_length(16'd1);
        run_command(CMD_NONE, 8'h00, 1'b0, -1);
        write_phase_length(16'd3);
        run_command(CMD_STOP, 8'h00, 1'b0, -1);
    endtask

    // mostly a bus transaction: start, address, a few bytes, stop on nack or at end
    task automatic run_random_transaction();
        logic is_read;
        int   n;
        if ($urandom_range(99) < 15) begin
            run_command(cmd_t'($urandom_range(7)), 8'($urandom), logic'($urandom_range(1)), -1);
            return;
        end
        is_read = logic'($urandom_range(1));
        run_command(CMD_START, 8'($urandom), logic'($urandom_range(1)), -1);
        run_command(CMD_WRITE, {7'($urandom), is_read}, logic'($urandom_range(1)), -1);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n && last_ack; i++) begin
            if (is_read) begin
                run_command(CMD_READ, 8'($urandom), logic'(i != n - 1), -1);
            end else begin
                run_command(CMD_WRITE, 8'($urandom), logic'($urandom_range(1)), -1);
            end
        end
        run_command(CMD_STOP, 8'($urandom), logic'($urandom_range(1)), -1);
        repeat ($urandom_range(2)) begin
            send_tick(($urandom_range(4) == 0) ? cmd_t'($urandom_range(6, 7)) : CMD_NONE,
                      8'($urandom), logic'($urandom_range(1)), logic'($urandom_range(1)));
        end
    endtask

    task automatic test_random_transfers();
        int gaps[4]   = '{0, 74, 0, 35};
        int stalls[4] = '{0, 0, 74, 35};
        int lens[4];
        int mark;
        lens = '{1, 1, 1, $urandom_range(1, 2)};
        for (int k = 0; k < 4; k++) begin
            write_phase_length(16'(lens[k]));
            gap_pct = gaps[k];
            stall_pct = stalls[k];
            mark = ticks_sent;
            while (ticks_sent - mark < PHASE_TICKS) run_random_transaction();
        end
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each result transfer with the oldest forecast
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pin_forecast.size() == 0) begin
                report_mismatch("result with nothing expected", 0, int'(m_tdata));
            end else begin
                mon_want = pin_forecast.pop_front();
                mon_got = m_tdata[12:0];
                if (mon_got.scl != mon_want.scl)
                    report_mismatch("scl_out", int'(mon_want.scl), int'(mon_got.scl));
                if (mon_got.sda != mon_want.sda)
                    report_mismatch("sda_out", int'(mon_want.sda), int'(mon_got.sda));
                if (mon_got.busy != mon_want.busy)
                    report_mismatch("busy_res", int'(mon_want.busy), int'(mon_got.busy));
                if (mon_got.done != mon_want.done)
                    report_mismatch("done_res", int'(mon_want.done), int'(mon_got.done));
                if (mon_got.ack != mon_want.ack)
                    report_mismatch("ack_received", int'(mon_want.ack), int'(mon_got.ack));
                if (mon_got.rd_byte != mon_want.rd_byte)
                    report_mismatch("read_data", int'(mon_want.rd_byte),
                                    int'(mon_got.rd_byte));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_each_command();
        test_phase_length_extremes();
        test_random_transfers();
        // drain the remaining results
        s_tvalid <= 1'b0;
        while (pin_forecast.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
